// ===== rtl/udec_pkg.sv =====
// package: shared constants and types for the usb endpoint controller
`default_nettype none
package udec_pkg;
	localparam int Endpoints = 16;
	localparam int FifoDepth = 64;
	localparam int EpW = 4;
	localparam int PtrW = 6;
	localparam int MemAw = EpW + PtrW;

	typedef enum logic [4:0] {
		REQ_EN = 5'd0, REQ_DIS = 5'd1, REQ_COUNT = 5'd2, REQ_IRQ_EN = 5'd3,
		REQ_IRQ_DIS = 5'd4, REQ_STALL = 5'd5, REQ_UNSTALL = 5'd6, REQ_STALL_Q = 5'd7,
		REQ_RESET = 5'd8, REQ_RAISE = 5'd9, REQ_CLEAR = 5'd10, REQ_EV_Q = 5'd11,
		REQ_ANY_Q = 5'd12, REQ_READ = 5'd13, REQ_WRITE = 5'd14, REQ_DEV_RAISE = 5'd15,
		REQ_DEV_CLEAR = 5'd16, REQ_DEV_EN = 5'd17, REQ_DEV_DIS = 5'd18,
		REQ_DEV_Q = 5'd19
	} req_t;

	localparam logic [1:0] EV_SETUP = 2'd0;
	localparam logic [1:0] EV_OUT = 2'd1;
	localparam logic [1:0] EV_IN = 2'd2;

	localparam logic [2:0] NOTE_NONE = 3'd0;
	localparam logic [2:0] NOTE_RXPOLL = 3'd1;
	localparam logic [2:0] NOTE_TXPOLL = 3'd2;
	localparam logic [2:0] NOTE_RXCMPL = 3'd3;
	localparam logic [2:0] NOTE_TXAVAL = 3'd4;

	typedef struct packed {
		logic [4:0] req_type;
		logic       dir;
		logic [3:0] endpoint;
		logic [1:0] ep_type;
		logic [1:0] event_kind;
		logic [2:0] dev_irq;
		logic [7:0] wr_byte;
	} req_item_t;

	typedef struct packed {
		logic [7:0] rsp_data;
		logic       irq_line;
		logic [2:0] note_kind;
		logic       note_dir;
		logic [3:0] note_ep;
		logic       last;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       dir;
		logic [3:0] ep;
	} note_t;

	// one access worth of results, held until all beats are sent
	typedef struct packed {
		logic [1:0]      n_notes;
		note_t [2:0]     notes;
		logic            irq;
		logic [7:0]      rsp;
		logic            rsp_from_mem;
	} acc_res_t;
endpackage
`default_nettype wire

// ===== rtl/udec_if.sv =====
// interface: valid/ready channel carrying one item
`default_nettype none
interface udec_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/udec_fifo_mem.sv =====
// fifo byte store: all endpoint buffers for one direction
`default_nettype none
module udec_fifo_mem
	import udec_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [MemAw-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic             re,
	input  wire logic [MemAw-1:0] raddr,
	output logic      [7:0]       rdata
);
	logic [7:0] mem [Endpoints*FifoDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/udec_core.sv =====
// endpoint state and the single pass that executes one access
`default_nettype none
module udec_core
	import udec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      go,
	input  wire req_item_t req,
	output acc_res_t       res,
	output logic           mem_re,
	output logic           mem_dir,
	output logic [MemAw-1:0] mem_raddr,
	output logic           mem_we_in,
	output logic           mem_we_out,
	output logic [MemAw-1:0] mem_waddr
);
	logic [PtrW-1:0] in_wc_q [Endpoints];
	logic [PtrW-1:0] out_wc_q [Endpoints];
	logic [PtrW-1:0] in_ri_q [Endpoints];
	logic [PtrW-1:0] out_ri_q [Endpoints];
	logic [2:0] in_kind_q [Endpoints];
	logic [2:0] out_kind_q [Endpoints];
	logic [15:0] setup_q, rx_q, tx_q, in_ie_q, out_ie_q, in_st_q, out_st_q;
	logic [7:0] dev_ev_q, dev_ie_q;

	logic [15:0] setup_n, rx_n, tx_n, in_ie_n, out_ie_n, in_st_n, out_st_n;
	logic [7:0] dev_ev_n, dev_ie_n;
	logic [15:0] b;
	logic [7:0] db;
	logic [3:0] ep;
	logic d;
	logic [1:0] nn;
	note_t [2:0] nt;
	logic [7:0] rsp;
	logic wr_in_kind, wr_out_kind;
	logic [2:0] new_in_kind, new_out_kind;
	logic rst_in, rst_out, inc_in_wc, inc_out_wc, inc_in_ri, inc_out_ri;
	logic in_ctl, out_ctl;

	function automatic logic [PtrW-1:0] wrap_next(input logic [PtrW-1:0] v);
		return (v == PtrW'(FifoDepth - 1)) ? '0 : v + 1'b1;
	endfunction

	always_comb begin
		ep = req.endpoint;
		d = req.dir;
		b = 16'(1) << ep;
		db = 8'(1) << req.dev_irq;
		in_ctl = (in_kind_q[ep][1:0] == 2'd0);
		out_ctl = (out_kind_q[ep][1:0] == 2'd0);
		setup_n = setup_q; rx_n = rx_q; tx_n = tx_q;
		in_ie_n = in_ie_q; out_ie_n = out_ie_q;
		in_st_n = in_st_q; out_st_n = out_st_q;
		dev_ev_n = dev_ev_q; dev_ie_n = dev_ie_q;
		nn = 2'd0;
		nt = '0;
		rsp = 8'd0;
		wr_in_kind = 1'b0; wr_out_kind = 1'b0;
		new_in_kind = 3'd0; new_out_kind = 3'd0;
		rst_in = 1'b0; rst_out = 1'b0;
		inc_in_wc = 1'b0; inc_out_wc = 1'b0; inc_in_ri = 1'b0; inc_out_ri = 1'b0;
		mem_re = 1'b0;
		case (req.req_type)
			REQ_EN: begin
				if (req.ep_type == 2'd0 || !d) begin
					wr_out_kind = 1'b1;
				end
				if (req.ep_type == 2'd0 || d) begin
					wr_in_kind = 1'b1;
				end
				new_in_kind = {1'b1, req.ep_type};
				new_out_kind = {1'b1, req.ep_type};
			end
			REQ_DIS: begin
				wr_out_kind = out_ctl || !d;
				wr_in_kind = out_ctl || d;
			end
			REQ_COUNT: rsp = {2'b0, d ? in_wc_q[ep] : out_wc_q[ep]};
			REQ_IRQ_EN: begin
				if (!d) out_ie_n = out_ie_q | b;
				else in_ie_n = in_ie_q | b;
				nn = 2'd1;
				nt[0] = '{d ? NOTE_TXPOLL : NOTE_RXPOLL, d, ep};
			end
			REQ_IRQ_DIS: begin
				if (!d) out_ie_n = out_ie_q & ~b;
				else in_ie_n = in_ie_q & ~b;
			end
			REQ_STALL: begin
				// order: setup clear (re-arms in), other event, own event
				if (!d) begin
					out_st_n = out_st_q | b;
					if (out_ctl) begin
						if ((setup_q & b) != 0) begin
							nt[nn] = '{NOTE_RXCMPL, 1'b0, ep}; nn = nn + 1'b1;
						end
						setup_n = setup_q & ~b;
						// in flag is re-armed then cleared with a note
						nt[nn] = '{NOTE_TXAVAL, 1'b1, ep}; nn = nn + 1'b1;
						tx_n = tx_q & ~b;
					end
					if ((rx_q & b) != 0) begin
						nt[nn] = '{NOTE_RXCMPL, 1'b0, ep}; nn = nn + 1'b1;
					end
					rx_n = rx_q & ~b;
				end else begin
					in_st_n = in_st_q | b;
					if (in_ctl) begin
						if ((setup_q & b) != 0) begin
							nt[nn] = '{NOTE_RXCMPL, 1'b0, ep}; nn = nn + 1'b1;
						end
						setup_n = setup_q & ~b;
						if ((rx_q & b) != 0) begin
							nt[nn] = '{NOTE_RXCMPL, 1'b0, ep}; nn = nn + 1'b1;
						end
						rx_n = rx_q & ~b;
						nt[nn] = '{NOTE_TXAVAL, 1'b1, ep}; nn = nn + 1'b1;
					end else if ((tx_q & b) != 0) begin
						nt[nn] = '{NOTE_TXAVAL, 1'b1, ep}; nn = nn + 1'b1;
					end
					tx_n = tx_q & ~b;
				end
			end
			REQ_UNSTALL, REQ_RESET: begin
				if (req.req_type == REQ_RESET) begin
					rst_in = d; rst_out = !d;
				end
				if (!d) out_st_n = out_st_q & ~b;
				else begin
					in_st_n = in_st_q & ~b;
					if (!in_ctl) tx_n = tx_q | b;
				end
			end
			REQ_STALL_Q: rsp = {7'd0, ((d ? in_st_q : out_st_q) & b) != 0};
			REQ_RAISE: begin
				case (req.event_kind)
					EV_SETUP: begin
						rst_in = 1'b1; rst_out = 1'b1;
						in_st_n = in_st_q & ~b;
						out_st_n = out_st_q & ~b;
						setup_n = setup_q | b;
						if (((tx_q | (in_ctl ? 16'd0 : b)) & b) != 0) begin
							nt[nn] = '{NOTE_TXAVAL, 1'b1, ep}; nn = nn + 1'b1;
						end
						tx_n = tx_q & ~b;
						if ((rx_q & b) != 0) begin
							nt[nn] = '{NOTE_RXCMPL, 1'b0, ep}; nn = nn + 1'b1;
						end
						rx_n = rx_q & ~b;
					end
					EV_OUT: rx_n = rx_q | b;
					EV_IN: tx_n = tx_q | b;
					default: ;
				endcase
			end
			REQ_CLEAR: begin
				case (req.event_kind)
					EV_SETUP: begin
						if ((setup_q & b) != 0) begin
							nt[0] = '{NOTE_RXCMPL, 1'b0, ep}; nn = 2'd1;
						end
						setup_n = setup_q & ~b;
						tx_n = tx_q | b;
					end
					EV_OUT: begin
						if ((rx_q & b) != 0) begin
							nt[0] = '{NOTE_RXCMPL, 1'b0, ep}; nn = 2'd1;
						end
						rx_n = rx_q & ~b;
					end
					EV_IN: begin
						if ((tx_q & b) != 0) begin
							nt[0] = '{NOTE_TXAVAL, 1'b1, ep}; nn = 2'd1;
						end
						tx_n = tx_q & ~b;
					end
					default: ;
				endcase
			end
			REQ_EV_Q: begin
				case (req.event_kind)
					EV_SETUP: rsp = {7'd0, (setup_q & b) != 0};
					EV_OUT: rsp = {7'd0, (rx_q & b) != 0};
					EV_IN: rsp = {7'd0, (tx_q & b) != 0};
					default: rsp = 8'd0;
				endcase
			end
			REQ_ANY_Q: rsp = {7'd0,
				(((out_ie_q & b) != 0) && (((setup_q | rx_q | out_st_q) & b) != 0)) ||
				(((in_ie_q & b) != 0) && (((tx_q | in_st_q) & b) != 0))};
			REQ_READ: begin
				mem_re = 1'b1;
				inc_in_ri = d; inc_out_ri = !d;
			end
			REQ_WRITE: begin
				inc_in_wc = d; inc_out_wc = !d;
			end
			REQ_DEV_RAISE: dev_ev_n = dev_ev_q | db;
			REQ_DEV_CLEAR: dev_ev_n = dev_ev_q & ~db;
			REQ_DEV_EN: dev_ie_n = dev_ie_q | db;
			REQ_DEV_DIS: dev_ie_n = dev_ie_q & ~db;
			REQ_DEV_Q: rsp = {7'd0, (dev_ev_q & db) != 0};
			default: ;
		endcase
		mem_re = mem_re & go;
		mem_dir = d;
		mem_raddr = {ep, d ? in_ri_q[ep] : out_ri_q[ep]};
		mem_waddr = {ep, d ? in_wc_q[ep] : out_wc_q[ep]};
		mem_we_in = go && inc_in_wc;
		mem_we_out = go && inc_out_wc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Endpoints; i++) begin
				in_wc_q[i] <= '0; out_wc_q[i] <= '0;
				in_ri_q[i] <= '0; out_ri_q[i] <= '0;
				in_kind_q[i] <= '0; out_kind_q[i] <= '0;
			end
			setup_q <= '0; rx_q <= '0; tx_q <= '0;
			in_ie_q <= '0; out_ie_q <= '0; in_st_q <= '0; out_st_q <= '0;
			dev_ev_q <= '0; dev_ie_q <= '0;
			res <= '0;
		end else if (go) begin
			setup_q <= setup_n; rx_q <= rx_n; tx_q <= tx_n;
			in_ie_q <= in_ie_n; out_ie_q <= out_ie_n;
			in_st_q <= in_st_n; out_st_q <= out_st_n;
			dev_ev_q <= dev_ev_n; dev_ie_q <= dev_ie_n;
			if (wr_in_kind) in_kind_q[ep] <= new_in_kind;
			if (wr_out_kind) out_kind_q[ep] <= new_out_kind;
			if (rst_in) begin
				in_wc_q[ep] <= '0; in_ri_q[ep] <= '0;
			end
			if (rst_out) begin
				out_wc_q[ep] <= '0; out_ri_q[ep] <= '0;
			end
			if (inc_in_wc) in_wc_q[ep] <= wrap_next(in_wc_q[ep]);
			if (inc_out_wc) out_wc_q[ep] <= wrap_next(out_wc_q[ep]);
			if (inc_in_ri) in_ri_q[ep] <= wrap_next(in_ri_q[ep]);
			if (inc_out_ri) out_ri_q[ep] <= wrap_next(out_ri_q[ep]);
			res.n_notes <= nn;
			res.notes <= nt;
			res.rsp <= rsp;
			res.rsp_from_mem <= (req.req_type == REQ_READ);
			res.irq <= ((dev_ev_n & dev_ie_n) != 0) || ((tx_n & in_ie_n) != 0) ||
				(((rx_n | setup_n) & out_ie_n) != 0);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/udec_out_seq.sv =====
// result sequencer: sends notification items then the final item
`default_nettype none
module udec_out_seq
	import udec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire acc_res_t  res,
	input  wire logic [7:0] rd_in,
	input  wire logic [7:0] rd_out,
	input  wire logic      rd_dir_s1,
	output logic           busy,
	udec_if.source         rsp_ch
);
	logic       active_q;
	logic [1:0] beat_q;
	logic [7:0] rsp_q;
	logic       fresh_q;
	logic [7:0] rsp_now;

	// memory data is valid in the cycle after the access; capture it then
	assign rsp_now = fresh_q ? (res.rsp_from_mem ? (rd_dir_s1 ? rd_in : rd_out) : res.rsp)
		: rsp_q;
	assign busy = active_q;
	assign rsp_ch.valid = active_q;

	always_comb begin
		rsp_ch.data = '0;
		rsp_ch.data.irq_line = res.irq;
		if (beat_q < res.n_notes) begin
			rsp_ch.data.note_kind = res.notes[beat_q].kind;
			rsp_ch.data.note_dir = res.notes[beat_q].dir;
			rsp_ch.data.note_ep = res.notes[beat_q].ep;
		end else begin
			rsp_ch.data.rsp_data = rsp_now;
			rsp_ch.data.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			beat_q <= '0;
			fresh_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			fresh_q <= start;
			if (fresh_q) rsp_q <= rsp_now;
			if (start) begin
				active_q <= 1'b1;
				beat_q <= '0;
			end else if (active_q && rsp_ch.ready) begin
				if (beat_q >= res.n_notes) active_q <= 1'b0;
				else beat_q <= beat_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/usb_device_endpoint_controller_top.sv =====
// top level: usb device endpoint controller
// usage:
//   req channel: one access per item (operation, direction, endpoint, type,
//   event kind, device event bit, write byte)
//   rsp channel: zero to three notification items followed by one final
//   item with last set, carrying the read byte, count or query flag
//   the first result item is valid in the cycle after the access is taken
//   rate: one result item per cycle while the receiver does not stall;
//   the result sequencer sets this rate, since the next access
//   is taken in the cycle the final item is taken
//   fifo bytes live in two 1024x8 memories, read data registered
//   reset clears all counts, flags, enables and endpoint types at once;
//   buffer contents are undefined until written
//   when the receiver stalls, the current result item holds and no new
//   access is taken
`default_nettype none
module usb_device_endpoint_controller_top
	import udec_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	udec_if.sink     req,
	udec_if.source   rsp
);
	acc_res_t         res;
	logic             busy, go, ending;
	logic             mem_re, mem_dir, we_in, we_out;
	logic [MemAw-1:0] raddr, waddr;
	logic [7:0]       rd_in, rd_out;
	logic             rd_dir_s1;

	// take a new access when idle or as the final item leaves
	assign ending = rsp.valid && rsp.ready && rsp.data.last;
	assign req.ready = !busy || ending;
	assign go = req.valid && req.ready;

	udec_core u_core (
		.clk, .arst_n, .go, .req(req.data), .res,
		.mem_re, .mem_dir, .mem_raddr(raddr),
		.mem_we_in(we_in), .mem_we_out(we_out), .mem_waddr(waddr)
	);

	udec_fifo_mem u_mem_in (
		.clk, .we(we_in), .waddr, .wdata(req.data.wr_byte),
		.re(mem_re && mem_dir), .raddr, .rdata(rd_in)
	);

	udec_fifo_mem u_mem_out (
		.clk, .we(we_out), .waddr, .wdata(req.data.wr_byte),
		.re(mem_re && !mem_dir), .raddr, .rdata(rd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_dir_s1 <= 1'b0;
		end else if (go) begin
			rd_dir_s1 <= mem_dir;
		end
	end

	udec_out_seq u_seq (
		.clk, .arst_n, .start(go), .res, .rd_in, .rd_out, .rd_dir_s1,
		.busy, .rsp_ch(rsp)
	);
endmodule
`default_nettype wire

// ===== test/usb_device_endpoint_controller_top_tb.sv =====
// testbench: random and directed accesses checked against a behavioral predictor
`timescale 1ns / 100ps
`default_nettype none
module usb_device_endpoint_controller_top_tb;
	import udec_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int MaxReports = 10;
	localparam int DrainCycles = 20;

	logic clk;
	logic arst_n;

	udec_if #(.T(req_item_t)) req ();
	udec_if #(.T(rsp_item_t)) rsp ();

	usb_device_endpoint_controller_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// clock: 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// predictor state, mirrors the controller registers
	// ---------------------------------------------------------------
	logic [7:0]  in_fifo [Endpoints*FifoDepth];
	logic [7:0]  out_fifo [Endpoints*FifoDepth];
	logic [5:0]  in_wr_cnt [Endpoints];
	logic [5:0]  out_wr_cnt [Endpoints];
	logic [5:0]  in_rd_idx [Endpoints];
	logic [5:0]  out_rd_idx [Endpoints];
	logic [2:0]  in_kind [Endpoints];
	logic [2:0]  out_kind [Endpoints];
	logic [15:0] setup_ev, rx_ev, tx_ev, in_ie, out_ie, in_stall, out_stall;
	logic [7:0]  dev_ev, dev_ie;

	rsp_item_t   pending_rsp [$];
	rsp_item_t   step_notes [$];
	req_item_t   pending_req [$];

	int n_errors;
	int n_checked;
	int n_accepted;
	int hold_off;

	function automatic logic is_ctrl(logic [2:0] kind);
		return kind[1:0] == 2'd0;
	endfunction

	function automatic void push_note(logic [2:0] kind, logic d, logic [3:0] ep);
		rsp_item_t r;
		if (step_notes.size() < 3) begin
			r = '0;
			r.note_kind = kind;
			r.note_dir = d;
			r.note_ep = ep;
			step_notes.push_back(r);
		end
	endfunction

	function automatic void pred_unstall(logic d, logic [3:0] ep);
		if (!d) begin
			out_stall[ep] = 1'b0;
		end else begin
			in_stall[ep] = 1'b0;
			if (!is_ctrl(in_kind[ep]))
				tx_ev[ep] = 1'b1;
		end
	endfunction

	function automatic void pred_fifo_reset(logic d, logic [3:0] ep);
		if (d) begin
			in_wr_cnt[ep] = '0;
			in_rd_idx[ep] = '0;
		end else begin
			out_wr_cnt[ep] = '0;
			out_rd_idx[ep] = '0;
		end
		pred_unstall(d, ep);
	endfunction

	function automatic void pred_clear(logic [3:0] ep, logic [1:0] ek);
		case (ek)
			EV_SETUP: begin
				if (setup_ev[ep]) begin
					setup_ev[ep] = 1'b0;
					push_note(NOTE_RXCMPL, 1'b0, ep);
				end
				// clearing setup re-arms the in side
				tx_ev[ep] = 1'b1;
			end
			EV_OUT: begin
				if (rx_ev[ep]) begin
					rx_ev[ep] = 1'b0;
					push_note(NOTE_RXCMPL, 1'b0, ep);
				end
			end
			EV_IN: begin
				if (tx_ev[ep]) begin
					tx_ev[ep] = 1'b0;
					push_note(NOTE_TXAVAL, 1'b1, ep);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void pred_raise(logic [3:0] ep, logic [1:0] ek);
		case (ek)
			EV_SETUP: begin
				pred_fifo_reset(1'b1, ep);
				pred_fifo_reset(1'b0, ep);
				setup_ev[ep] = 1'b1;
				pred_clear(ep, EV_IN);
				pred_clear(ep, EV_OUT);
			end
			EV_OUT: rx_ev[ep] = 1'b1;
			EV_IN: tx_ev[ep] = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic void pred_stall(logic d, logic [3:0] ep);
		if (!d) begin
			out_stall[ep] = 1'b1;
			if (is_ctrl(out_kind[ep])) begin
				pred_clear(ep, EV_SETUP);
				pred_clear(ep, EV_IN);
			end
			pred_clear(ep, EV_OUT);
		end else begin
			in_stall[ep] = 1'b1;
			if (is_ctrl(in_kind[ep])) begin
				pred_clear(ep, EV_SETUP);
				pred_clear(ep, EV_OUT);
			end
			pred_clear(ep, EV_IN);
		end
	endfunction

	// applies one access to the predictor and queues its expected results
	function automatic void predict_access(req_item_t it);
		logic [7:0] answer;
		logic [3:0] ep;
		logic [7:0] dbit;
		logic irq;
		rsp_item_t fin;
		int base;
		answer = '0;
		ep = it.endpoint;
		dbit = 8'd1 << it.dev_irq;
		base = int'(ep) * FifoDepth;
		step_notes.delete();
		case (it.req_type)
			REQ_EN: begin
				if (it.ep_type == 2'd0) begin
					out_kind[ep] = {1'b1, it.ep_type};
					in_kind[ep] = {1'b1, it.ep_type};
				end else if (!it.dir) begin
					out_kind[ep] = {1'b1, it.ep_type};
				end else begin
					in_kind[ep] = {1'b1, it.ep_type};
				end
			end
			REQ_DIS: begin
				if (is_ctrl(out_kind[ep])) begin
					out_kind[ep] = '0;
					in_kind[ep] = '0;
				end else if (!it.dir) begin
					out_kind[ep] = '0;
				end else begin
					in_kind[ep] = '0;
				end
			end
			REQ_COUNT: answer = {2'b0, it.dir ? in_wr_cnt[ep] : out_wr_cnt[ep]};
			REQ_IRQ_EN: begin
				if (!it.dir) begin
					out_ie[ep] = 1'b1;
					push_note(NOTE_RXPOLL, 1'b0, ep);
				end else begin
					in_ie[ep] = 1'b1;
					push_note(NOTE_TXPOLL, 1'b1, ep);
				end
			end
			REQ_IRQ_DIS: begin
				if (!it.dir) out_ie[ep] = 1'b0;
				else in_ie[ep] = 1'b0;
			end
			REQ_STALL: pred_stall(it.dir, ep);
			REQ_UNSTALL: pred_unstall(it.dir, ep);
			REQ_STALL_Q: answer = {7'b0, it.dir ? in_stall[ep] : out_stall[ep]};
			REQ_RESET: pred_fifo_reset(it.dir, ep);
			REQ_RAISE: pred_raise(ep, it.event_kind);
			REQ_CLEAR: pred_clear(ep, it.event_kind);
			REQ_EV_Q: begin
				case (it.event_kind)
					EV_SETUP: answer = {7'b0, setup_ev[ep]};
					EV_OUT: answer = {7'b0, rx_ev[ep]};
					EV_IN: answer = {7'b0, tx_ev[ep]};
					default: answer = '0;
				endcase
			end
			REQ_ANY_Q: begin
				// a direction with its interrupt disabled contributes nothing
				answer = {7'b0,
					(out_ie[ep] & (setup_ev[ep] | rx_ev[ep] | out_stall[ep])) |
					(in_ie[ep] & (tx_ev[ep] | in_stall[ep]))};
			end
			REQ_READ: begin
				if (!it.dir) begin
					answer = out_fifo[base + int'(out_rd_idx[ep])];
					out_rd_idx[ep] = out_rd_idx[ep] + 6'd1;
				end else begin
					answer = in_fifo[base + int'(in_rd_idx[ep])];
					in_rd_idx[ep] = in_rd_idx[ep] + 6'd1;
				end
			end
			REQ_WRITE: begin
				if (it.dir) begin
					in_fifo[base + int'(in_wr_cnt[ep])] = it.wr_byte;
					in_wr_cnt[ep] = in_wr_cnt[ep] + 6'd1;
				end else begin
					out_fifo[base + int'(out_wr_cnt[ep])] = it.wr_byte;
					out_wr_cnt[ep] = out_wr_cnt[ep] + 6'd1;
				end
			end
			REQ_DEV_RAISE: dev_ev = dev_ev | dbit;
			REQ_DEV_CLEAR: dev_ev = dev_ev & ~dbit;
			REQ_DEV_EN: dev_ie = dev_ie | dbit;
			REQ_DEV_DIS: dev_ie = dev_ie & ~dbit;
			REQ_DEV_Q: answer = {7'b0, |(dev_ev & dbit)};
			default: ;
		endcase
		irq = |(dev_ev & dev_ie) | |(tx_ev & in_ie) | |((rx_ev | setup_ev) & out_ie);
		foreach (step_notes[k]) begin
			step_notes[k].irq_line = irq;
			pending_rsp.push_back(step_notes[k]);
		end
		fin = '0;
		fin.rsp_data = answer;
		fin.irq_line = irq;
		fin.last = 1'b1;
		pending_rsp.push_back(fin);
	endfunction

	// ---------------------------------------------------------------
	// stimulus generation, keeps reads on written bytes only
	// ---------------------------------------------------------------
	logic [5:0] gen_in_wr [Endpoints];
	logic [5:0] gen_out_wr [Endpoints];
	logic [5:0] gen_in_rd [Endpoints];
	logic [5:0] gen_out_rd [Endpoints];
	int gen_in_avail [Endpoints];
	int gen_out_avail [Endpoints];

	// tracks fifo pointers at generation time so that reads stay legal
	function automatic req_item_t legalize(req_item_t it);
		int ep;
		ep = int'(it.endpoint);
		if (it.req_type == REQ_READ) begin
			if ((it.dir ? gen_in_avail[ep] : gen_out_avail[ep]) == 0)
				it.req_type = REQ_WRITE;
		end
		case (it.req_type)
			REQ_WRITE: begin
				if (it.dir) begin
					gen_in_wr[ep] = gen_in_wr[ep] + 6'd1;
					if (gen_in_avail[ep] < FifoDepth) gen_in_avail[ep]++;
				end else begin
					gen_out_wr[ep] = gen_out_wr[ep] + 6'd1;
					if (gen_out_avail[ep] < FifoDepth) gen_out_avail[ep]++;
				end
			end
			REQ_READ: begin
				if (it.dir) begin
					gen_in_rd[ep] = gen_in_rd[ep] + 6'd1;
					gen_in_avail[ep]--;
				end else begin
					gen_out_rd[ep] = gen_out_rd[ep] + 6'd1;
					gen_out_avail[ep]--;
				end
			end
			REQ_RESET: begin
				if (it.dir) begin
					gen_in_wr[ep] = '0; gen_in_rd[ep] = '0; gen_in_avail[ep] = 0;
				end else begin
					gen_out_wr[ep] = '0; gen_out_rd[ep] = '0; gen_out_avail[ep] = 0;
				end
			end
			REQ_RAISE: begin
				if (it.event_kind == EV_SETUP) begin
					gen_in_wr[ep] = '0; gen_in_rd[ep] = '0; gen_in_avail[ep] = 0;
					gen_out_wr[ep] = '0; gen_out_rd[ep] = '0; gen_out_avail[ep] = 0;
				end
			end
			default: ;
		endcase
		return it;
	endfunction

	function automatic req_item_t rand_item();
		req_item_t it;
		it.req_type = 5'($urandom_range(0, 31));
		// mostly valid operations, a few unknown codes
		if ($urandom_range(0, 15) != 0)
			it.req_type = 5'($urandom_range(0, 19));
		it.dir = 1'($urandom);
		// concentrate on a few endpoints so events and data interact
		it.endpoint = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
		it.ep_type = 2'($urandom);
		it.event_kind = 2'($urandom);
		it.dev_irq = 3'($urandom);
		it.wr_byte = 8'($urandom);
		return it;
	endfunction

	function automatic req_item_t mk(req_t op, logic d, logic [3:0] ep, logic [1:0] ty,
		logic [1:0] ek, logic [2:0] dv, logic [7:0] wb);
		req_item_t it;
		it.req_type = op;
		it.dir = d;
		it.endpoint = ep;
		it.ep_type = ty;
		it.event_kind = ek;
		it.dev_irq = dv;
		it.wr_byte = wb;
		return it;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	initial begin
		req_item_t it;
		int n;
		foreach (gen_in_wr[i]) begin
			gen_in_wr[i] = '0; gen_out_wr[i] = '0;
			gen_in_rd[i] = '0; gen_out_rd[i] = '0;
			gen_in_avail[i] = 0; gen_out_avail[i] = 0;
		end
		// directed: every operation, field extremes, the cascades
		pending_req.push_back(legalize(mk(REQ_EN, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_IRQ_EN, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_IRQ_EN, 1'b1, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_WRITE, 1'b1, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'hff)));
		pending_req.push_back(legalize(mk(REQ_WRITE, 1'b0, 4'd15, 2'd3, EV_SETUP, 3'd7, 8'h80)));
		pending_req.push_back(legalize(mk(REQ_COUNT, 1'b1, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_READ, 1'b0, 4'd15, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_RAISE, 1'b0, 4'd0, 2'd0, EV_OUT, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_RAISE, 1'b0, 4'd0, 2'd0, EV_IN, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_RAISE, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_EV_Q, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_ANY_Q, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_STALL, 1'b1, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_STALL_Q, 1'b1, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_EN, 1'b1, 4'd1, 2'd2, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_UNSTALL, 1'b1, 4'd1, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_RESET, 1'b1, 4'd1, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_CLEAR, 1'b0, 4'd1, 2'd0, 2'd3, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_EV_Q, 1'b0, 4'd1, 2'd0, 2'd3, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_IRQ_DIS, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_DIS, 1'b1, 4'd1, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_DEV_RAISE, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd7, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_DEV_EN, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd7, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_DEV_Q, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd7, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_DEV_CLEAR, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd7, 8'h00)));
		pending_req.push_back(legalize(mk(REQ_DEV_DIS, 1'b0, 4'd0, 2'd0, EV_SETUP, 3'd0, 8'h00)));
		pending_req.push_back(legalize(mk(req_t'(5'd31), 1'b1, 4'd15, 2'd3, 2'd3, 3'd7, 8'hff)));
		// random part, including fifo wrap through long write runs
		n = 0;
		while (n < 350) begin
			if ($urandom_range(0, 19) == 0) begin
				// burst of writes then reads on one fifo, may wrap
				it = mk(REQ_WRITE, 1'($urandom), 4'($urandom_range(0, 2)), 2'd0,
					EV_SETUP, 3'd0, 8'h00);
				repeat ($urandom_range(5, 70)) begin
					it.wr_byte = 8'($urandom);
					pending_req.push_back(legalize(it));
					n++;
				end
				it.req_type = REQ_READ;
				repeat ($urandom_range(1, 10)) begin
					pending_req.push_back(legalize(it));
					n++;
				end
			end else begin
				pending_req.push_back(legalize(rand_item()));
				n++;
			end
		end
	end

	// ---------------------------------------------------------------
	// reset and predictor initialization
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		foreach (in_wr_cnt[i]) begin
			in_wr_cnt[i] = '0; out_wr_cnt[i] = '0;
			in_rd_idx[i] = '0; out_rd_idx[i] = '0;
			in_kind[i] = '0; out_kind[i] = '0;
		end
		setup_ev = '0; rx_ev = '0; tx_ev = '0; in_ie = '0; out_ie = '0;
		in_stall = '0; out_stall = '0; dev_ev = '0; dev_ie = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------
	// driver: offers items on the falling edge with random gaps
	// ---------------------------------------------------------------
	int req_gap;
	bit req_fire;

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		req_gap = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			// an item accepted at the last rising edge leaves the queue
			if (req_fire) begin
				void'(pending_req.pop_front());
				req_gap = gap_len();
			end
			if (req_gap > 0) begin
				req_gap--;
				req.valid <= 1'b0;
			end else if (pending_req.size() > 0) begin
				req.valid <= 1'b1;
				req.data <= pending_req[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver ready: random stalls plus one long hold-off
	// ---------------------------------------------------------------
	int rsp_gap;
	bit long_hold_done;

	initial begin
		rsp.ready = 1'b0;
		rsp_gap = 0;
		hold_off = 0;
		long_hold_done = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && n_accepted == 60) begin
				// hold off long enough for the block to back up its input
				long_hold_done <= 1'b1;
				hold_off <= 200;
				rsp.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				rsp.ready <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					rsp_gap <= gap_len();
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: predicts on accepted access, checks each result item
	// ---------------------------------------------------------------
	int idle_cycles;

	initial begin
		n_errors = 0;
		n_checked = 0;
		n_accepted = 0;
		idle_cycles = 0;
		req_fire = 1'b0;
	end

	always @(posedge clk) begin
		rsp_item_t want;
		rsp_item_t got;
		req_fire <= arst_n && req.valid && req.ready;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				predict_access(req.data);
				n_accepted <= n_accepted + 1;
			end
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				n_checked <= n_checked + 1;
				if (pending_rsp.size() == 0) begin
					n_errors <= n_errors + 1;
					if (n_errors < MaxReports)
						$display("unexpected result item %p", got);
				end else begin
					want = pending_rsp.pop_front();
					if (got !== want) begin
						n_errors <= n_errors + 1;
						if (n_errors < MaxReports)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// end of run and watchdog
	// ---------------------------------------------------------------
	initial begin
		wait (arst_n);
		fork
			begin
				wait (pending_req.size() == 0 && !req.valid && pending_rsp.size() == 0);
				repeat (DrainCycles) @(posedge clk);
				$display("covered %0d accesses, %0d result items checked, %0d mismatches",
					n_accepted, n_checked, n_errors);
				if (n_errors == 0 && pending_rsp.size() == 0)
					$display("Simulation PASSED");
				else
					$display("Simulation FAILED");
				$finish;
			end
			begin
				wait (idle_cycles >= WatchdogLimit);
				$display("watchdog: no progress for %0d cycles", WatchdogLimit);
				$display("Simulation FAILED");
				$finish;
			end
		join
	end
endmodule
`default_nettype wire
